@@ src/sdp_pkg.sv @@
package sdp_pkg;

	// Parser phases
	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_FAILED = 2'd3
	} phase_t;

	// Parser state carried from one byte to the next
	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic [32:0] mag;
		logic [3:0]  count;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{phase: PH_LEAD, neg: 1'b0, mag: '0, count: '0};

	// Character codes
	localparam logic [7:0] CHAR_TERM  = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Magnitude limits, sized to the product width
	localparam logic [35:0] POS_LIMIT = 36'd2147483647;
	localparam logic [35:0] NEG_LIMIT = 36'd2147483648;
	localparam logic [32:0] MAG_ONE   = 33'd1;

endpackage

@@ src/sdp_char_if.sv @@
interface sdp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

@@ src/sdp_result_if.sv @@
interface sdp_result_if;
	logic               valid;
	logic               ready;
	logic               parse_ok;
	logic signed [31:0] seed_value;

	modport source (output valid, output parse_ok, output seed_value, input ready);
	modport sink   (input valid, input parse_ok, input seed_value, output ready);
endinterface

@@ src/signed_decimal_int32_parser.sv @@
// Signed decimal parser: takes one character byte per request and, on each zero
// byte, returns one result holding parse_ok and the signed 32-bit value (zero when
// the string is rejected: empty, lone minus, stray character, more than MAX_DIGITS
// digits, out of range, or minus one). One byte is accepted every cycle unless the
// input register is stalled; the byte is held in the input register, then the parser
// state and the result register are updated from it, so a result is offered from the
// result register once its zero byte leaves the input register. A result waiting at
// the output stalls the next zero byte in the input register, and the bytes behind
// it, until the result is taken; bytes ahead of that zero byte keep flowing.
module signed_decimal_int32_parser #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	sdp_char_if.sink            char_ch,
	sdp_result_if.source        result_ch
);

	logic                  valid_s1;
	logic [7:0]            char_s1;
	sdp_pkg::parse_state_t state_q;
	sdp_pkg::parse_state_t state_d;
	logic                  term_s1;
	logic                  ok_d;
	logic signed [31:0]    value_d;
	logic                  out_valid_q;
	logic                  ok_q;
	logic signed [31:0]    value_q;
	logic                  out_free;
	logic                  advance;

	sdp_step #(.MAX_DIGITS(MAX_DIGITS)) u_step (
		.state_cur  (state_q),
		.char_code  (char_s1),
		.state_nxt  (state_d),
		.is_term    (term_s1),
		.parse_ok   (ok_d),
		.seed_value (value_d)
	);

	// Handshake: a terminator moves on only when the result slot is free
	assign out_free      = !out_valid_q || result_ch.ready;
	assign advance       = valid_s1 && (!term_s1 || out_free);
	assign char_ch.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.char_code;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdp_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && term_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && term_s1) begin
			ok_q    <= ok_d;
			value_q <= value_d;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.parse_ok   = ok_q;
	assign result_ch.seed_value = value_q;

endmodule

@@ src/sdp_step.sv @@
module sdp_step #(
	parameter int MAX_DIGITS = 10
) (
	input  sdp_pkg::parse_state_t state_cur,
	input  logic [7:0]            char_code,
	output sdp_pkg::parse_state_t state_nxt,
	output logic                  is_term,
	output logic                  parse_ok,
	output logic signed [31:0]    seed_value
);

	localparam logic [3:0] MaxCount = 4'(MAX_DIGITS);

	logic        is_digit;
	logic [3:0]  digit;
	logic [35:0] next_mag;
	logic [35:0] limit;
	logic        digit_fail;
	logic        ok;

	// Character class and digit value
	assign is_term  = (char_code == sdp_pkg::CHAR_TERM);
	assign is_digit = (char_code >= sdp_pkg::CHAR_ZERO) && (char_code <= sdp_pkg::CHAR_NINE);
	assign digit    = 4'(char_code - sdp_pkg::CHAR_ZERO);

	// mag * 10 + digit as shift-add
	assign next_mag = {state_cur.mag, 3'b000} + {2'b00, state_cur.mag, 1'b0} + {32'd0, digit};
	assign limit    = state_cur.neg ? sdp_pkg::NEG_LIMIT : sdp_pkg::POS_LIMIT;
	assign digit_fail = (state_cur.count >= MaxCount) || (next_mag > limit);

	// Result on terminator; minus one is rejected
	assign ok = (state_cur.phase == sdp_pkg::PH_DIGITS) &&
		!(state_cur.neg && (state_cur.mag == sdp_pkg::MAG_ONE));
	assign parse_ok = ok;

	always_comb begin
		if (!ok) begin
			seed_value = '0;
		end else if (state_cur.neg) begin
			seed_value = 32'sd0 - $signed(state_cur.mag[31:0]);
		end else begin
			seed_value = $signed(state_cur.mag[31:0]);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_cur;
		if (is_term) begin
			state_nxt = sdp_pkg::STATE_RESET;
		end else begin
			unique case (state_cur.phase)
				sdp_pkg::PH_LEAD: begin
					if (char_code == sdp_pkg::CHAR_SPACE) begin
						state_nxt = state_cur;
					end else if (char_code == sdp_pkg::CHAR_MINUS) begin
						state_nxt.neg   = 1'b1;
						state_nxt.phase = sdp_pkg::PH_SIGN;
					end else if (is_digit && !digit_fail) begin
						state_nxt.mag   = next_mag[32:0];
						state_nxt.count = state_cur.count + 4'd1;
						state_nxt.phase = sdp_pkg::PH_DIGITS;
					end else begin
						state_nxt.phase = sdp_pkg::PH_FAILED;
					end
				end
				sdp_pkg::PH_SIGN, sdp_pkg::PH_DIGITS: begin
					if (is_digit && !digit_fail) begin
						state_nxt.mag   = next_mag[32:0];
						state_nxt.count = state_cur.count + 4'd1;
						state_nxt.phase = sdp_pkg::PH_DIGITS;
					end else begin
						state_nxt.phase = sdp_pkg::PH_FAILED;
					end
				end
				sdp_pkg::PH_FAILED: begin
					state_nxt = state_cur;
				end
				default: begin
					state_nxt = state_cur;
				end
			endcase
		end
	end

endmodule

@@ src/sdp_checker.sv @@
module sdp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               parse_ok,
	input logic signed [31:0] seed_value
);

	// A stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(parse_ok) && $stable(seed_value))
		else $error("result payload changed while stalled");

	// Rejected strings report zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_ok |-> seed_value == 32'sd0)
		else $error("rejected result carries a nonzero value");

	// Minus one is never reported as valid
	a_no_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_ok |-> seed_value != -32'sd1)
		else $error("minus one accepted");

endmodule

bind signed_decimal_int32_parser sdp_checker u_sdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.parse_ok   (result_ch.parse_ok),
	.seed_value (result_ch.seed_value)
);
